@@ rtl/mps_pkg.sv @@
// shared types and constants of the motion plan sequencer
package mps_pkg;

   // channel widths
   localparam int REQ_TYPE_W  = 2;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_SENSOR = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK   = 2'd2;

   // plan entry opcodes
   localparam logic [2:0] OP_HALT = 3'd1;
   localparam logic [2:0] OP_ARC  = 3'd2;
   localparam logic [2:0] OP_SPIN = 3'd3;
   localparam logic [2:0] OP_LED  = 3'd4;

   // motion modes
   localparam logic [1:0] MODE_PARKED = 2'd0;
   localparam logic [1:0] MODE_ARC    = 2'd1;
   localparam logic [1:0] MODE_SPIN   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAN_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_SPEED = 1'd1;

   // turn test in q8: |sum|*TURN_COEF + TURN_BIAS >= |goal|*GOAL_COEF
   localparam logic [17:0] TURN_COEF = 18'd92160;
   localparam logic [17:0] GOAL_COEF = 18'd207496;
   localparam logic [35:0] TURN_BIAS = 36'd2489952;

   typedef struct packed {
      logic signed [15:0] angle_delta;
      logic signed [15:0] arg_c;
      logic signed [15:0] arg_b;
      logic signed [15:0] arg_a;
      logic [2:0]         opcode;
      logic [4:0]         entry_index;
   } req_data_type;

   typedef struct packed {
      logic [2:0]         pad;
      logic               plan_done;
      logic [1:0]         motion_mode;
      logic [7:0]         blue_level;
      logic [7:0]         green_level;
      logic [7:0]         red_level;
      logic signed [15:0] turn_radius;
      logic signed [9:0]  velocity;
   } rsp_data_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [15:0] arg_a;
      logic signed [15:0] arg_b;
      logic signed [15:0] arg_c;
   } plan_entry_type;

   typedef struct packed {
      logic mul_en;
      logic sel_goal;
      logic hold_lhs;
   } turn_ctl_type;

endpackage

@@ rtl/mps_ram.sv @@
// generic single write port ram with registered read
module mps_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/mps_turn_unit.sv @@
// shared multiplier and compare for the turn target test
module mps_turn_unit (
   input  logic                 clock,
   input  logic signed [15:0]   angle_sum,
   input  logic signed [15:0]   angle_goal,
   input  mps_pkg::turn_ctl_type ctl,
   output logic                 reached
);

   import mps_pkg::*;

   logic signed [16:0] sum_ext;
   logic signed [16:0] goal_ext;
   logic [16:0]        abs_sum;
   logic [16:0]        abs_goal;
   logic [16:0]        opnd;
   logic [17:0]        coef;
   logic [34:0]        prod;
   logic [34:0]        prod_ff;
   logic [35:0]        lhs_ff;

   always_comb begin
      sum_ext  = {angle_sum[15], angle_sum};
      goal_ext = {angle_goal[15], angle_goal};
      abs_sum  = sum_ext[16] ? 17'(-sum_ext) : 17'(sum_ext);
      abs_goal = goal_ext[16] ? 17'(-goal_ext) : 17'(goal_ext);
      opnd     = ctl.sel_goal ? abs_goal : abs_sum;
      coef     = ctl.sel_goal ? GOAL_COEF : TURN_COEF;
      prod     = 35'(opnd) * 35'(coef);
   end

   // first pass holds the turn product, second pass the goal product
   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod;
      end
      if (ctl.hold_lhs) begin
         lhs_ff <= 36'(prod_ff) + TURN_BIAS;
      end
   end

   assign reached = (lhs_ff >= 36'(prod_ff));

endmodule

@@ rtl/motion_plan_sequencer_top.sv @@
// motion plan sequencer: plan store, step sequencer and output register
//
// Runs a stored plan of drive commands. A load word writes one plan entry, a sensor word
// adds its angle change to a wrapping 16-bit accumulator, and a tick word advances the
// plan when the robot is parked with steps left or has turned close enough to its target.
// Every accepted word gives one result word with the drive and LED state after it. The
// block takes one word at a time. A load, sensor or ignored word, or a tick that takes no
// step, goes straight to the done state, which loads the result register once the output
// is free. When the robot is moving, a tick first runs the turn test (one multiplier
// used twice, then a compare). Each plan entry a tick visits passes through a plan store
// read, then decode, and stepping past the end of the plan takes the read step alone.
// Set-led entries chain straight into the next step. A result that waits on the receiver
// holds the block in its done state. The plan store has no reset; reading an entry never
// loaded gives undefined drive fields.
module motion_plan_sequencer_top #(
   parameter int PLAN_DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mps_pkg::REQ_TYPE_W-1:0]   req_tuser,  // req_type
   // entry_index[4:0], opcode[7:5], arg_a[23:8], arg_b[39:24], arg_c[55:40],
   // angle_delta[71:56]
   input  logic [mps_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // velocity[9:0], turn_radius[25:10], red_level[33:26], green_level[41:34],
   // blue_level[49:42], motion_mode[51:50], plan_done[52], zero[55:53]
   output logic [mps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [mps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mps_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import mps_pkg::*;

   localparam int AW  = (PLAN_DEPTH > 1) ? $clog2(PLAN_DEPTH) : 1;
   localparam int SPW = $clog2(PLAN_DEPTH + 2) + 1;
   localparam logic signed [SPW-1:0] SP_MAX   = SPW'(PLAN_DEPTH + 1);
   localparam logic signed [SPW-1:0] SP_ONE   = SPW'(1);
   localparam logic signed [SPW-1:0] SP_RESET = '1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_STEP = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_MUL1 = 3'd3;
   localparam logic [2:0] ST_MUL2 = 3'd4;
   localparam logic [2:0] ST_CMP  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic signed [SPW-1:0] sp_ff, sp_in;
   logic [1:0]            mode_ff, mode_in;
   logic signed [15:0]    sum_ff, sum_in;
   logic signed [15:0]    goal_ff, goal_in;
   logic signed [9:0]     vel_ff, vel_in;
   logic signed [15:0]    radius_ff, radius_in;
   logic [7:0]            red_ff, red_in;
   logic [7:0]            green_ff, green_in;
   logic [7:0]            blue_ff, blue_in;
   logic [5:0]            len_ff, len_in;
   logic signed [9:0]     speed_ff, speed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   req_data_type          req_d;
   logic                  req_acc;
   logic                  out_free;
   logic signed [SPW-1:0] eff_len;
   logic signed [SPW-1:0] sp_inc;
   logic                  step_end;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [AW-1:0]         ram_raddr;
   plan_entry_type        ram_wdata;
   logic [$bits(plan_entry_type)-1:0] ram_rdata;
   plan_entry_type        entry;
   turn_ctl_type          turn_ctl;
   logic                  reached;

   assign req_d      = req_data_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign eff_len  = (32'(len_ff) < PLAN_DEPTH) ? $signed(SPW'(len_ff))
                                                : $signed(SPW'(PLAN_DEPTH));
   assign sp_inc   = (sp_ff < SP_MAX) ? SPW'(sp_ff + SP_ONE) : sp_ff;
   assign step_end = (sp_inc >= eff_len) || sp_inc[SPW-1];

   assign ram_waddr = AW'(req_d.entry_index);
   assign ram_raddr = sp_inc[AW-1:0];
   assign ram_wdata = '{opcode: req_d.opcode, arg_a: req_d.arg_a,
                        arg_b: req_d.arg_b, arg_c: req_d.arg_c};
   assign entry     = plan_entry_type'(ram_rdata);

   mps_ram #(
      .WIDTH  ($bits(plan_entry_type)),
      .DEPTH  (PLAN_DEPTH),
      .ADDR_W (AW)
   ) u_plan_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mps_turn_unit u_turn (
      .clock      (clock),
      .angle_sum  (sum_ff),
      .angle_goal (goal_ff),
      .ctl        (turn_ctl),
      .reached    (reached)
   );

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      mode_in      = mode_ff;
      sum_in       = sum_ff;
      goal_in      = goal_ff;
      vel_in       = vel_ff;
      radius_in    = radius_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      len_in       = len_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      turn_ctl     = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_PLAN_LENGTH: len_in   = csr_wdata[5:0];
            CSR_DRIVE_SPEED: speed_in = $signed(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_DONE;
               unique case (req_tuser)
                  REQ_LOAD: begin
                     ram_we = (32'(req_d.entry_index) < PLAN_DEPTH);
                  end
                  REQ_SENSOR: begin
                     sum_in = 16'(sum_ff + req_d.angle_delta);
                  end
                  REQ_TICK: begin
                     if (mode_ff == MODE_PARKED) begin
                        if (sp_ff < eff_len) begin
                           state_in = ST_STEP;
                        end
                     end else if (mode_ff == MODE_ARC || mode_ff == MODE_SPIN) begin
                        state_in = ST_MUL1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_STEP: begin
            sp_in = sp_inc;
            if (step_end) begin
               mode_in   = MODE_PARKED;
               vel_in    = '0;
               radius_in = '0;
               red_in    = '0;
               green_in  = '0;
               blue_in   = '0;
               state_in  = ST_DONE;
            end else begin
               sum_in   = '0;
               goal_in  = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (entry.opcode)
               OP_HALT: begin
                  mode_in   = MODE_PARKED;
                  vel_in    = '0;
                  radius_in = '0;
                  red_in    = '0;
                  green_in  = '0;
                  blue_in   = '0;
               end
               OP_ARC: begin
                  mode_in   = MODE_ARC;
                  goal_in   = entry.arg_b;
                  vel_in    = speed_ff;
                  radius_in = entry.arg_a;
               end
               OP_SPIN: begin
                  mode_in   = MODE_SPIN;
                  goal_in   = entry.arg_a;
                  vel_in    = speed_ff;
                  radius_in = (entry.arg_a <= 16'sd0) ? 16'sd1 : -16'sd1;
               end
               OP_LED: begin
                  // led entries chain straight into the next step
                  red_in   = entry.arg_a[7:0];
                  green_in = entry.arg_b[7:0];
                  blue_in  = entry.arg_c[7:0];
                  state_in = ST_STEP;
               end
               default: ;
            endcase
         end
         ST_MUL1: begin
            turn_ctl.mul_en = 1'b1;
            state_in        = ST_MUL2;
         end
         ST_MUL2: begin
            turn_ctl.mul_en   = 1'b1;
            turn_ctl.sel_goal = 1'b1;
            turn_ctl.hold_lhs = 1'b1;
            state_in          = ST_CMP;
         end
         ST_CMP: begin
            state_in = reached ? ST_STEP : ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.pad          = '0;
               rsp_data_in.plan_done    = (sp_ff >= eff_len);
               rsp_data_in.motion_mode  = mode_ff;
               rsp_data_in.blue_level   = blue_ff;
               rsp_data_in.green_level  = green_ff;
               rsp_data_in.red_level    = red_ff;
               rsp_data_in.turn_radius  = radius_ff;
               rsp_data_in.velocity     = vel_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= SP_RESET;
         mode_ff      <= MODE_PARKED;
         sum_ff       <= '0;
         goal_ff      <= '0;
         vel_ff       <= '0;
         radius_ff    <= '0;
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         len_ff       <= '0;
         speed_ff     <= 10'sd150;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         mode_ff      <= mode_in;
         sum_ff       <= sum_in;
         goal_ff      <= goal_in;
         vel_ff       <= vel_in;
         radius_ff    <= radius_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         len_ff       <= len_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a parked robot never carries a drive command
   a_parked_still: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_PARKED |-> vel_ff == 10'sd0 && radius_ff == 16'sd0)
      else $error("parked with nonzero drive command");

   // the step pointer stays between its reset value and one past the store depth
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff >= SP_RESET && sp_ff <= SP_MAX)
      else $error("step pointer out of range");

   // plan entries are written only from an accepted load word
   a_store_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE && req_acc && req_tuser == REQ_LOAD)
      else $error("plan store written outside a load");

   // a result word appears only after the sequencer finished an item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised without a finished item");
`endif

endmodule

@@ bench/motion_plan_sequencer_checker.sv @@
// channel monitor, plan sequencer predictor and result word checker
`timescale 1ns / 100ps

module motion_plan_sequencer_checker #(
   parameter int PLAN_DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [mps_pkg::REQ_TYPE_W-1:0]   req_tuser,
   input  logic [mps_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [mps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [mps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mps_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               error_count,
   output int                               words_pending
);
   import mps_pkg::*;

   plan_entry_type     plan_mem [PLAN_DEPTH];
   int                 step_ptr;
   logic [1:0]         drive_mode;
   logic signed [15:0] turn_sum;
   logic signed [15:0] turn_goal;
   logic signed [9:0]  cmd_velocity;
   logic signed [15:0] cmd_radius;
   logic [7:0]         led_level [3];
   logic [5:0]         cfg_plan_len;
   logic signed [9:0]  cfg_speed;
   rsp_data_type       expected_status [$];

   function automatic int plan_limit();
      return (cfg_plan_len < PLAN_DEPTH) ? int'(cfg_plan_len) : PLAN_DEPTH;
   endfunction

   // turn plus 12 degrees has reached the goal, in q8 fixed point
   function automatic bit turn_done();
      longint mag_sum;
      longint mag_goal;
      mag_sum  = (turn_sum < 0) ? -longint'(turn_sum) : longint'(turn_sum);
      mag_goal = (turn_goal < 0) ? -longint'(turn_goal) : longint'(turn_goal);
      return mag_sum * longint'(TURN_COEF) + longint'(TURN_BIAS)
             >= mag_goal * longint'(GOAL_COEF);
   endfunction

   task automatic park_robot();
      drive_mode   = MODE_PARKED;
      cmd_velocity = '0;
      cmd_radius   = '0;
      foreach (led_level[j]) led_level[j] = '0;
   endtask

   // led entries fall through to the next entry, so walk with a bound
   task automatic advance_plan();
      plan_entry_type ent;
      int hops;
      for (hops = 0; hops <= PLAN_DEPTH + 1; hops++) begin
         if (step_ptr < PLAN_DEPTH + 1) step_ptr++;
         if (step_ptr >= plan_limit() || step_ptr < 0) begin
            park_robot();
            return;
         end
         turn_sum  = '0;
         turn_goal = '0;
         ent = plan_mem[step_ptr];
         case (ent.opcode)
            OP_HALT: begin
               park_robot();
               return;
            end
            OP_ARC: begin
               drive_mode   = MODE_ARC;
               turn_goal    = ent.arg_b;
               cmd_velocity = cfg_speed;
               cmd_radius   = ent.arg_a;
               return;
            end
            OP_SPIN: begin
               drive_mode   = MODE_SPIN;
               turn_goal    = ent.arg_a;
               cmd_velocity = cfg_speed;
               cmd_radius   = (ent.arg_a <= 0) ? 16'sd1 : -16'sd1;
               return;
            end
            OP_LED: begin
               led_level[0] = ent.arg_a[7:0];
               led_level[1] = ent.arg_b[7:0];
               led_level[2] = ent.arg_c[7:0];
            end
            default: return;
         endcase
      end
   endtask

   task automatic apply_word(input logic [REQ_TYPE_W-1:0] kind, input req_data_type w);
      case (kind)
         REQ_LOAD: plan_mem[w.entry_index] = '{w.opcode, w.arg_a, w.arg_b, w.arg_c};
         REQ_SENSOR: turn_sum = turn_sum + w.angle_delta;
         REQ_TICK: begin
            if (drive_mode == MODE_PARKED) begin
               if (step_ptr < plan_limit()) advance_plan();
            end else if (drive_mode == MODE_ARC || drive_mode == MODE_SPIN) begin
               if (turn_done()) advance_plan();
            end
         end
         default: ;
      endcase
   endtask

   function automatic rsp_data_type status_word();
      rsp_data_type s;
      s = '0;
      s.velocity    = cmd_velocity;
      s.turn_radius = cmd_radius;
      s.red_level   = led_level[0];
      s.green_level = led_level[1];
      s.blue_level  = led_level[2];
      s.motion_mode = drive_mode;
      s.plan_done   = (step_ptr >= plan_limit());
      return s;
   endfunction

   task automatic check_field(input string name, input longint want, input longint seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_data_type want;
      rsp_data_type seen;
      if (reset) begin
         foreach (plan_mem[j]) plan_mem[j] = '0;
         step_ptr     = -1;
         turn_sum     = '0;
         turn_goal    = '0;
         cfg_plan_len = '0;
         cfg_speed    = 10'sd150;
         park_robot();
         expected_status.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PLAN_LENGTH) cfg_plan_len = csr_wdata[5:0];
            else if (csr_index == CSR_DRIVE_SPEED) cfg_speed = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               $error("result word with nothing expected: %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_status.pop_front();
               seen = rsp_tdata;
               check_field("velocity", want.velocity, seen.velocity);
               check_field("turn_radius", want.turn_radius, seen.turn_radius);
               check_field("red_level", want.red_level, seen.red_level);
               check_field("green_level", want.green_level, seen.green_level);
               check_field("blue_level", want.blue_level, seen.blue_level);
               check_field("motion_mode", want.motion_mode, seen.motion_mode);
               check_field("plan_done", want.plan_done, seen.plan_done);
               check_field("pad", want.pad, seen.pad);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_word(req_tuser, req_data_type'(req_tdata));
            expected_status.push_back(status_word());
         end
      end
      words_pending = expected_status.size();
   end

endmodule

@@ bench/testbench.sv @@
// stimulus, clock, reset and verdict for the motion plan sequencer
`timescale 1ns / 100ps

module testbench;
   import mps_pkg::*;

   localparam int PLAN_DEPTH = 32;

   // codes the block treats as unknown or ignores
   localparam logic [2:0]            OP_NONE     = 3'd0;
   localparam logic [2:0]            OP_SPARE_LO = 3'd5;
   localparam logic [2:0]            OP_SPARE_HI = 3'd7;
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE   = 2'd3;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TYPE_W-1:0]   req_tuser  = '0;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;
   int                      error_count;
   int                      words_pending;

   int                      burst_left = 0;
   bit [PLAN_DEPTH-1:0]     loaded = '0;
   bit                      hold_request = 1'b0;

   motion_plan_sequencer_top #(.PLAN_DEPTH(PLAN_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   motion_plan_sequencer_checker #(.PLAN_DEPTH(PLAN_DEPTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .words_pending(words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("testbench: errors");
      $finish;
   end

   // result side: ready in spans of its own, plus one long hold-off on request
   initial begin : receiver
      int span;
      int style;
      int beat;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (399) @(negedge clock);
         end
         style = $urandom_range(0, 3);
         span  = $urandom_range(10, 120);
         for (beat = 0; beat < span; beat++) begin
            @(negedge clock);
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 9) < 7);
               2: rsp_tready <= (beat % 4 == 3);
               default: rsp_tready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   function automatic req_data_type random_word();
      req_data_type w;
      w.entry_index = 5'($urandom);
      w.opcode      = 3'($urandom);
      w.arg_a       = 16'($urandom);
      w.arg_b       = 16'($urandom);
      w.arg_c       = 16'($urandom);
      w.angle_delta = 16'($urandom);
      return w;
   endfunction

   // goals the accumulated angle can actually reach, mostly small
   function automatic logic signed [15:0] reachable_goal();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick == 1) return ($urandom_range(0, 1)) ? 16'sd12 : -16'sd13;
      if (pick < 18) return 16'($urandom_range(0, 1200) - 600);
      return 16'($urandom_range(0, 6000) - 3000);
   endfunction

   function automatic req_data_type plan_word(input logic [4:0] idx);
      req_data_type w;
      int pick;
      w = random_word();
      w.entry_index = idx;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         w.opcode = OP_LED;
      end else if (pick < 5) begin
         w.opcode = OP_ARC;
         w.arg_b  = reachable_goal();
      end else if (pick < 7) begin
         w.opcode = OP_SPIN;
         w.arg_a  = reachable_goal();
      end else if (pick == 7) begin
         w.opcode = OP_HALT;
      end else begin
         w.opcode = (pick == 8) ? OP_NONE : 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      return w;
   endfunction

   // called and returns at a falling edge; valid stays up inside a burst
   task automatic send_word(input logic [REQ_TYPE_W-1:0] kind, input req_data_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (kind == REQ_LOAD) loaded[w.entry_index] = 1'b1;
   endtask

   task automatic tick();
      send_word(REQ_TICK, random_word());
   endtask

   task automatic sense(input logic signed [15:0] delta);
      req_data_type w;
      w = random_word();
      w.angle_delta = delta;
      send_word(REQ_SENSOR, w);
   endtask

   task automatic load_entry(input logic [4:0] idx, input logic [2:0] op,
                             input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic signed [15:0] c);
      req_data_type w;
      w = random_word();
      w.entry_index = idx;
      w.opcode      = op;
      w.arg_a       = a;
      w.arg_b       = b;
      w.arg_c       = c;
      send_word(REQ_LOAD, w);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      wait (words_pending == 0);
      @(negedge clock);
   endtask

   task automatic write_config(input logic [5:0] plan_len, input logic signed [9:0] speed);
      drain();
      repeat (10) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_PLAN_LENGTH;
      csr_wdata <= CSR_DATA_W'(plan_len);
      @(negedge clock);
      csr_index <= CSR_DRIVE_SPEED;
      csr_wdata <= speed;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int phase_len [8];
      int phase_speed [8];
      int k;
      int n;
      int pick;
      int lim;
      int i;
      logic signed [9:0] speed;

      phase_len   = '{14, 20, 26, 0, 32, 63, 12, 63};
      phase_speed = '{500, 0, -1, 150, -500, 500, 77, -333};

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // wrapping sum, ignored type, and a first tick that ends an empty plan
      sense(16'sh7FFF);
      sense(-16'sh8000);
      send_word(REQ_SPARE, '1);
      tick();
      load_entry(5'd1, OP_LED, 16'sh7FFF, -16'sh8000, -16'sd1);
      load_entry(5'd2, OP_LED, 16'sh0055, 16'sh00AA, 16'sh0000);
      load_entry(5'd3, OP_ARC, -16'sh8000, -16'sd12, 16'sd0);
      load_entry(5'd4, OP_SPIN, 16'sd0, 16'sh7FFF, 16'sd0);
      load_entry(5'd5, OP_SPIN, -16'sd13, 16'sd0, 16'sd0);
      load_entry(5'd6, OP_NONE, 16'sd0, 16'sd0, 16'sd0);
      load_entry(5'd7, OP_SPIN, 16'sd5, 16'sd0, 16'sd0);
      load_entry(5'd8, OP_HALT, -16'sd1, -16'sd1, -16'sd1);
      load_entry(5'd9, OP_SPARE_HI, 16'sd0, 16'sd0, 16'sd0);
      load_entry(5'd31, OP_SPARE_LO, 16'sh7FFF, -16'sh8000, 16'sh7FFF);

      write_config(6'd10, -10'sd500);
      tick();            // two chained led entries, then the arc
      tick();            // goal of 12 is met with no turn at all
      tick();            // spin with a goal of -13
      sense(16'sd2);
      tick();            // one short of the goal
      sense(16'sd1);
      tick();            // unknown entry keeps the spin, clears the goal
      tick();
      tick();            // halt
      tick();            // parked on an unknown entry
      tick();            // past the end
      tick();

      for (k = 0; k < 8; k++) begin
         speed = (k == 6) ? 10'($urandom_range(0, 1000) - 500) : 10'(phase_speed[k]);
         write_config(6'(phase_len[k]), speed);
         if (k == 1) hold_request = 1'b1;
         lim = (phase_len[k] < PLAN_DEPTH) ? phase_len[k] : PLAN_DEPTH;
         for (i = 0; i < lim; i++)
            if (!loaded[i]) send_word(REQ_LOAD, plan_word(5'(i)));
         for (n = 0; n < 75; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
               tick();
            else if (pick < 60)
               sense(($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 800) - 150)
                                                   : 16'($urandom));
            else if (pick < 85)
               send_word(REQ_LOAD, plan_word(5'($urandom)));
            else if (pick < 97)
               send_word(REQ_SPARE, random_word());
            else begin
               drain();
               n--;
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
